@@ sv/dtt_pkg.sv @@
// shared types, constants and helpers of the deadline timer table
package dtt_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [31:0] DEFAULT_THRESHOLD = 32'd3600000;
  localparam logic [47:0] ALL_ONES48 = '1;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_RESET   = 3'd3,
    OP_QUERY   = 3'd4,
    OP_COLLECT = 3'd5
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_ACTIVE = 2'd1,
    ST_FULL       = 2'd2
  } status_e_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_WR,
    S_RD,
    S_RDD,
    S_SCAN_ST,
    S_SCAN_RD,
    S_SCAN_END,
    S_EMIT,
    S_COLL_CHK,
    S_COLL_PICK,
    S_COLL_EMIT,
    S_COLL_RD,
    S_COLL_UPD,
    S_COLL_NEXT
  } state_t;

  typedef struct packed {
    logic      load;
    logic      scan_start;
    logic      scan_mark;
    logic      scan_rd;
    logic      tgt_free;
    logic      tgt_best;
    logic      upd;
    logic      set_prev;
    logic      emit;
    logic      emit_slot;
    logic      front_chk;
    status_e_t status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       free_any;
    logic       slot_valid;
    logic       slot_ok;
    logic       noop;
    logic       active_tgt;
    logic       scan_last;
    logic       best_v;
    logic       mark_any;
    logic       more;
    logic       out_free;
  } stat_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? ALL_ONES48 : s[47:0];
  endfunction

endpackage

@@ sv/dtt_ctrl.sv @@
// sequencer of the deadline timer table
module dtt_ctrl import dtt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t    state, state_next;
  state_t    ret, ret_next;
  status_e_t res_status, res_status_next;
  logic      res_slot, res_slot_next;
  logic      res_front, res_front_next;
  logic      mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      res_status <= ST_OK;
      res_slot   <= 1'b0;
      res_front  <= 1'b0;
      mode       <= 1'b0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_front  <= res_front_next;
      mode       <= mode_next;
    end
  end

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_front_next  = res_front;
    mode_next       = mode;
    cmd             = '0;
    cmd.status      = res_status;
    cmd.emit_slot   = res_slot;
    cmd.front_chk   = res_front;
    cmd.scan_mark   = mode;
    in_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_slot_next  = 1'b0;
        res_front_next = 1'b0;
        res_status_next = ST_OK;
        unique case (st.op)
          OP_ADD: begin
            if (st.free_any) begin
              cmd.tgt_free = 1'b1;
              state_next   = S_ADD_WR;
            end else begin
              res_status_next = ST_FULL;
              state_next      = S_EMIT;
            end
          end
          OP_CANCEL: begin
            if (st.slot_ok) begin
              cmd.upd = 1'b1;
            end else begin
              res_status_next = ST_NOT_ACTIVE;
            end
            state_next = S_EMIT;
          end
          OP_REFRESH: begin
            if (st.slot_ok) begin
              state_next = S_RD;
            end else begin
              res_status_next = ST_NOT_ACTIVE;
              state_next      = S_EMIT;
            end
          end
          OP_RESET: begin
            if (st.slot_valid) begin
              state_next = S_RD;
            end else begin
              res_status_next = ST_NOT_ACTIVE;
              state_next      = S_EMIT;
            end
          end
          OP_QUERY: begin
            mode_next  = 1'b0;
            ret_next   = S_EMIT;
            state_next = S_SCAN_ST;
          end
          OP_COLLECT: begin
            mode_next  = 1'b0;
            ret_next   = S_COLL_CHK;
            state_next = S_SCAN_ST;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ADD_WR: begin
        cmd.upd         = 1'b1;
        res_slot_next   = 1'b1;
        res_front_next  = 1'b1;
        mode_next       = 1'b0;
        ret_next        = S_EMIT;
        state_next      = S_SCAN_ST;
      end
      S_RD: state_next = S_RDD;
      S_RDD: begin
        if (st.op == OP_REFRESH) begin
          cmd.upd    = 1'b1;
          state_next = S_EMIT;
        end else if (st.noop) begin
          state_next = S_EMIT;
        end else if (!st.active_tgt) begin
          res_status_next = ST_NOT_ACTIVE;
          state_next      = S_EMIT;
        end else begin
          cmd.upd        = 1'b1;
          res_front_next = 1'b1;
          mode_next      = 1'b0;
          ret_next       = S_EMIT;
          state_next     = S_SCAN_ST;
        end
      end
      S_SCAN_ST: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: state_next = ret;
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_COLL_CHK: begin
        state_next = S_IDLE;
        if (st.best_v) begin
          cmd.set_prev = 1'b1;
          if (st.mark_any) begin
            mode_next       = 1'b1;
            ret_next        = S_COLL_PICK;
            res_status_next = ST_OK;
            res_slot_next   = 1'b1;
            res_front_next  = 1'b0;
            state_next      = S_SCAN_ST;
          end
        end
      end
      S_COLL_PICK: begin
        cmd.tgt_best = 1'b1;
        state_next   = S_COLL_EMIT;
      end
      S_COLL_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_COLL_RD;
        end
      end
      S_COLL_RD: state_next = S_COLL_UPD;
      S_COLL_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_COLL_NEXT;
      end
      S_COLL_NEXT: state_next = st.more ? S_SCAN_ST : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> state == S_DECODE)
    else $error("accepted transaction not decoded");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("input ready outside idle");
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> st.out_free)
    else $error("result issued while output register busy");

endmodule

@@ sv/dtt_dp.sv @@
// timer storage, scan unit and result register of the deadline timer table
module dtt_dp import dtt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  operation,
  input  logic [3:0]  slot,
  input  logic [31:0] interval_ms,
  input  logic        recurring,
  input  logic        restart,
  input  logic [47:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  slot_out,
  output logic        front_new,
  output logic [47:0] delay_ms,
  output logic        expired,
  output logic        last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [2:0]  op_q;
  logic [3:0]  slot_q;
  logic [31:0] ival_q;
  logic        rec_q;
  logic        fnow_q;
  logic [47:0] now_q;
  logic [31:0] thr;
  logic [47:0] prev_time;
  logic        front_n;

  logic [SLOTS-1:0] active, rep, pw, mark;
  logic [47:0] dl_mem [SLOTS];
  logic [31:0] per_mem [SLOTS];
  logic [47:0] dl_rd;
  logic [31:0] per_rd;
  logic        pw_rd;

  logic [IW-1:0]    tgt, ra, scan_idx, sidx, best_idx, free_idx;
  logic             sv, mode_q, roll, best_v;
  logic [47:0]      best_dl;
  logic [CNT_W-1:0] cnt;

  logic        free_any, slot_valid, cand, coll_last, front_hit;
  logic [31:0] per_eff;
  logic [47:0] start, qd;
  logic        dl_we, per_we;
  logic [47:0] dl_wd;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign slot_valid = ({28'b0, slot_q} < 32'(SLOTS));
  assign per_eff    = pw_rd ? per_rd : 32'b0;
  assign start      = (dl_rd >= {16'b0, per_eff}) ? dl_rd - {16'b0, per_eff} : 48'b0;
  assign ra         = cmd.scan_rd ? scan_idx : tgt;
  assign cand       = mode_q ? mark[sidx] : active[sidx];
  assign coll_last  = (cnt == CNT_W'(MAX_RESULTS - 1)) ||
                      ((mark & ~(SLOTS'(1) << tgt)) == '0);
  assign front_hit  = cmd.front_chk && best_v && (best_idx == tgt) && !front_n;
  assign qd         = !best_v ? ALL_ONES48 : (now_q >= best_dl) ? 48'b0 : best_dl - now_q;

  always_comb begin
    st            = '0;
    st.op         = op_q;
    st.free_any   = free_any;
    st.slot_valid = slot_valid;
    st.slot_ok    = slot_valid && active[tgt];
    st.noop       = (ival_q == per_eff) && !fnow_q;
    st.active_tgt = active[tgt];
    st.scan_last  = (scan_idx == IW'(SLOTS - 1));
    st.best_v     = best_v;
    st.mark_any   = |mark;
    st.more       = (|mark) && (cnt < CNT_W'(MAX_RESULTS));
    st.out_free   = !out_valid || out_ready;
  end

  // memory write selection
  always_comb begin
    dl_we  = 1'b0;
    per_we = 1'b0;
    dl_wd  = sat_add48(now_q, ival_q);
    if (cmd.upd) begin
      case (op_q)
        OP_ADD: begin
          dl_we  = 1'b1;
          per_we = 1'b1;
        end
        OP_REFRESH: begin
          dl_we = 1'b1;
          dl_wd = sat_add48(now_q, per_eff);
        end
        OP_RESET: begin
          dl_we  = 1'b1;
          per_we = 1'b1;
          dl_wd  = sat_add48(fnow_q ? now_q : start, ival_q);
        end
        OP_COLLECT: begin
          dl_we = rep[tgt];
          dl_wd = sat_add48(now_q, per_eff);
        end
        default: dl_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[tgt] <= dl_wd;
    end
    if (per_we) begin
      per_mem[tgt] <= ival_q;
    end
    dl_rd  <= dl_mem[ra];
    per_rd <= per_mem[ra];
    pw_rd  <= pw[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      slot_q <= slot;
      ival_q <= interval_ms;
      rec_q  <= recurring;
      fnow_q <= restart;
      now_q  <= now_ms;
    end
    if (cmd.load) begin
      tgt <= IW'(slot);
    end else if (cmd.tgt_free) begin
      tgt <= free_idx;
    end else if (cmd.tgt_best) begin
      tgt <= best_idx;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
      mode_q   <= cmd.scan_mark;
      roll     <= (now_q < prev_time) && ((prev_time - now_q) > {16'b0, thr});
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + 1'b1;
    end
    sidx <= scan_idx;
    if (sv && cand && (!best_v || dl_rd < best_dl)) begin
      best_idx <= sidx;
      best_dl  <= dl_rd;
    end
    if (cmd.emit) begin
      status    <= cmd.status;
      slot_out  <= cmd.emit_slot ? 4'(tgt) : 4'b0;
      front_new <= front_hit;
      delay_ms  <= (op_q == OP_QUERY) ? qd : 48'b0;
      expired   <= (op_q == OP_COLLECT);
      last      <= (op_q != OP_COLLECT) || coll_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      rep       <= '0;
      pw        <= '0;
      mark      <= '0;
      sv        <= 1'b0;
      best_v    <= 1'b0;
      cnt       <= '0;
      thr       <= DEFAULT_THRESHOLD;
      prev_time <= '0;
      front_n   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sv <= cmd.scan_rd;
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (cmd.load) begin
        cnt <= '0;
      end
      if (cmd.set_prev) begin
        prev_time <= now_q;
      end
      if (cmd.scan_start) begin
        best_v <= 1'b0;
        if (!cmd.scan_mark) begin
          mark <= '0;
        end
      end else if (sv) begin
        if (!mode_q) begin
          mark[sidx] <= active[sidx] && (roll || dl_rd <= now_q);
        end
        if (cand) begin
          best_v <= 1'b1;
        end
      end
      if (cmd.upd) begin
        case (op_q)
          OP_ADD: begin
            active[tgt] <= 1'b1;
            rep[tgt]    <= rec_q;
            pw[tgt]     <= 1'b1;
          end
          OP_CANCEL: active[tgt] <= 1'b0;
          OP_RESET: pw[tgt] <= 1'b1;
          OP_COLLECT: begin
            mark[tgt] <= 1'b0;
            cnt       <= cnt + 1'b1;
            if (!rep[tgt]) begin
              active[tgt] <= 1'b0;
            end
          end
          default: cnt <= cnt;
        endcase
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (front_hit) begin
          front_n <= 1'b1;
        end else if (op_q == OP_QUERY) begin
          front_n <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrites a pending transaction");
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && op_q == OP_COLLECT |=> out_valid && expired)
    else $error("collect result not flagged expired");
  assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(MAX_RESULTS))
    else $error("collect count beyond cap");

endmodule

@@ sv/deadline_timer_table.sv @@
// Table of SLOTS software timers with ordered expiry. One transaction is handled at a
// time. Every step that needs the earliest deadline walks the deadline memory through
// its single read port, one slot a cycle. Query, add, a reset that rewrites the timer
// and collect walk it, collect once more for each slot that it emits; cancel, a
// full-table add, a reset of an out-of-range slot, refresh and the other resets do not.
// A result waits in an output register; the next transaction is taken while it waits,
// and a later result stalls until it is taken.
module deadline_timer_table import dtt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [3:0]  slot,
  input  logic [31:0] interval_ms,
  input  logic        recurring,
  input  logic        restart,
  input  logic [47:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  slot_out,
  output logic        front_new,
  output logic [47:0] delay_ms,
  output logic        expired,
  output logic        last
);

  cmd_t  cmd;
  stat_t st;

  dtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  dtt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .slot        (slot),
    .interval_ms (interval_ms),
    .recurring   (recurring),
    .restart     (restart),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot_out    (slot_out),
    .front_new   (front_new),
    .delay_ms    (delay_ms),
    .expired     (expired),
    .last        (last)
  );

endmodule

@@ sim/deadline_timer_table_test.sv @@
// self-checking testbench of the deadline timer table: directed table, random traffic, predictor
`timescale 1ns / 1ps
module deadline_timer_table_test import dtt_pkg::*; ();

  localparam int N_SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int N_RANDOM = 212;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] interval;
    logic        rec;
    logic        restart;
    logic [47:0] now;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        front;
    logic [47:0] delay;
    logic        expired;
    logic        last;
  } timer_resp_t;

  typedef struct {
    timer_cmd_t  cmd;
    logic        has_resp;
    timer_resp_t resp;
  } directed_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic [3:0] slot = '0;
  logic [31:0] interval_ms = '0;
  logic recurring = 0;
  logic restart = 0;
  logic [47:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [3:0] slot_out;
  logic front_new;
  logic [47:0] delay_ms;
  logic expired;
  logic last;

  deadline_timer_table #(.SLOTS(N_SLOTS)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .slot(slot),
    .interval_ms(interval_ms), .recurring(recurring), .restart(restart), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .slot_out(slot_out),
    .front_new(front_new), .delay_ms(delay_ms), .expired(expired), .last(last)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  logic [47:0] tm_deadline [N_SLOTS];
  logic [31:0] tm_period [N_SLOTS];
  logic        tm_repeat [N_SLOTS];
  logic        tm_active [N_SLOTS];
  logic [47:0] tm_prev_time;
  logic        tm_notified;
  logic [31:0] tm_threshold;

  timer_resp_t expected_resp_q[$];
  timer_resp_t last_pred;
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit long_stall_req = 0;
  logic [47:0] clock_ms = 48'd5000;

  function automatic logic [47:0] sum_sat(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic bit orders_first(int a, int b);
    if (tm_deadline[a] != tm_deadline[b]) return tm_deadline[a] < tm_deadline[b];
    return a < b;
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < N_SLOTS; i++)
      if (tm_active[i] && (best < 0 || orders_first(i, best))) best = i;
    return best;
  endfunction

  function automatic logic front_check(int s);
    if (earliest_slot() == s && !tm_notified) begin
      tm_notified = 1;
      return 1;
    end
    return 0;
  endfunction

  function automatic timer_resp_t single(logic [1:0] st, logic [3:0] s, logic f,
                                         logic [47:0] d);
    timer_resp_t r;
    r = '{status: st, slot: s, front: f, delay: d, expired: 1'b0, last: 1'b1};
    return r;
  endfunction

  task automatic expect_resp(timer_resp_t r);
    expected_resp_q = {expected_resp_q, r};
    last_pred = r;
  endtask

  task automatic predict_timers(timer_cmd_t c);
    logic [47:0] start;
    logic [47:0] d;
    logic mark [N_SLOTS];
    logic roll;
    int e;
    int b;
    int n;
    int cnt;
    timer_resp_t r;
    case (c.op)
      OP_ADD: begin
        b = -1;
        for (int i = 0; i < N_SLOTS; i++)
          if (b < 0 && !tm_active[i]) b = i;
        if (b < 0) expect_resp(single(ST_FULL, 0, 0, 0));
        else begin
          tm_active[b] = 1;
          tm_period[b] = c.interval;
          tm_repeat[b] = c.rec;
          tm_deadline[b] = sum_sat(c.now, c.interval);
          expect_resp(single(ST_OK, b[3:0], front_check(b), 0));
        end
      end
      OP_CANCEL: begin
        if (tm_active[c.slot]) begin
          tm_active[c.slot] = 0;
          expect_resp(single(ST_OK, 0, 0, 0));
        end else expect_resp(single(ST_NOT_ACTIVE, 0, 0, 0));
      end
      OP_REFRESH: begin
        if (tm_active[c.slot]) begin
          tm_deadline[c.slot] = sum_sat(c.now, tm_period[c.slot]);
          expect_resp(single(ST_OK, 0, 0, 0));
        end else expect_resp(single(ST_NOT_ACTIVE, 0, 0, 0));
      end
      OP_RESET: begin
        if (c.interval == tm_period[c.slot] && !c.restart)
          expect_resp(single(ST_OK, 0, 0, 0));
        else if (!tm_active[c.slot])
          expect_resp(single(ST_NOT_ACTIVE, 0, 0, 0));
        else begin
          if (c.restart) start = c.now;
          else if (tm_deadline[c.slot] >= {16'b0, tm_period[c.slot]})
            start = tm_deadline[c.slot] - {16'b0, tm_period[c.slot]};
          else start = 0;
          tm_period[c.slot] = c.interval;
          tm_deadline[c.slot] = sum_sat(start, c.interval);
          expect_resp(single(ST_OK, 0, front_check(c.slot), 0));
        end
      end
      OP_QUERY: begin
        tm_notified = 0;
        e = earliest_slot();
        if (e < 0) d = '1;
        else if (c.now >= tm_deadline[e]) d = 0;
        else d = tm_deadline[e] - c.now;
        expect_resp(single(ST_OK, 0, 0, d));
      end
      OP_COLLECT: begin
        e = earliest_slot();
        if (e >= 0) begin
          roll = c.now < tm_prev_time && (tm_prev_time - c.now) > {16'b0, tm_threshold};
          tm_prev_time = c.now;
          if (roll || tm_deadline[e] <= c.now) begin
            cnt = 0;
            for (int i = 0; i < N_SLOTS; i++) begin
              mark[i] = tm_active[i] && (roll || tm_deadline[i] <= c.now);
              if (mark[i]) cnt++;
            end
            if (cnt > MAX_RESULTS) cnt = MAX_RESULTS;
            n = 0;
            while (n < cnt) begin
              b = -1;
              for (int i = 0; i < N_SLOTS; i++)
                if (mark[i] && (b < 0 || orders_first(i, b))) b = i;
              if (b < 0) break;
              mark[b] = 0;
              r = '{status: ST_OK, slot: b[3:0], front: 1'b0, delay: '0, expired: 1'b1,
                    last: (n == cnt - 1)};
              expect_resp(r);
              n++;
              if (tm_repeat[b]) tm_deadline[b] = sum_sat(c.now, tm_period[b]);
              else tm_active[b] = 0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // result checking
  always @(posedge clk) begin
    timer_resp_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_resp_q.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        w = expected_resp_q.pop_front();
        if (status !== w.status) report_mismatch("status", status, w.status);
        if (slot_out !== w.slot) report_mismatch("slot_out", slot_out, w.slot);
        if (front_new !== w.front) report_mismatch("front_new", front_new, w.front);
        if (delay_ms !== w.delay) report_mismatch("delay_ms", delay_ms, w.delay);
        if (expired !== w.expired) report_mismatch("expired", expired, w.expired);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
    end
  end

  // receiver with random stalls and one long hold-off on request
  always @(posedge clk) begin
    int k;
    if (rst) out_ready <= 0;
    else if (long_stall_req && !hold_off) begin
      hold_off = 1;
      out_ready <= 0;
      for (k = 0; k < 600; k++) @(posedge clk);
      hold_off = 0;
      long_stall_req = 0;
    end else if ($urandom_range(0, 99) < 25) begin
      out_ready <= 0;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (k) @(posedge clk);
    end else out_ready <= 1;
  end

  // watchdog on cycles without any accepted transaction or taken result, outside a hold-off
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_cmd(timer_cmd_t c);
    operation <= c.op;
    slot <= c.slot;
    interval_ms <= c.interval;
    recurring <= c.rec;
    restart <= c.restart;
    now_ms <= c.now;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timers(c);
    if ($urandom_range(0, 99) < 30) begin
      in_valid <= 0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 2))
        @(posedge clk);
    end
  endtask

  task automatic write_threshold(logic [31:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (expected_resp_q.size() != 0) @(posedge clk);
    repeat (40 * N_SLOTS) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    tm_threshold = v;
  endtask

  function automatic timer_cmd_t mk(logic [2:0] op, logic [3:0] s, logic [31:0] iv,
                                    logic rc, logic fn, logic [47:0] t);
    timer_cmd_t c;
    c = '{op: op, slot: s, interval: iv, rec: rc, restart: fn, now: t};
    return c;
  endfunction

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int p;
    logic [31:0] iv;
    p = $urandom_range(0, 99);
    if (p < 80) clock_ms = clock_ms + $urandom_range(0, 60);
    else if (p < 88) clock_ms = clock_ms - $urandom_range(0, 200);
    else if (p < 93) clock_ms = (clock_ms > 48'd4000000) ? clock_ms - 48'd3700000 : clock_ms;
    else if (p < 96) clock_ms = 48'({$urandom, $urandom});
    else clock_ms = clock_ms + 48'd4000000;
    iv = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 150);
    p = $urandom_range(0, 99);
    c.op = p < 30 ? OP_ADD : p < 40 ? OP_CANCEL : p < 50 ? OP_REFRESH :
           p < 62 ? OP_RESET : p < 72 ? OP_QUERY : p < 97 ? OP_COLLECT :
           3'($urandom_range(6, 7));
    c.slot = 4'($urandom);
    c.interval = iv;
    c.rec = 1'($urandom);
    c.restart = 1'($urandom);
    c.now = clock_ms;
    return c;
  endfunction

  directed_row_t dir_rows[$];
  timer_cmd_t rc;

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      tm_deadline[i] = 0; tm_period[i] = 0; tm_repeat[i] = 0; tm_active[i] = 0;
    end
    tm_prev_time = 0;
    tm_notified = 0;
    tm_threshold = DEFAULT_THRESHOLD;

    dir_rows = '{
      '{mk(OP_QUERY, 0, 0, 0, 0, 100), 1, single(ST_OK, 0, 0, '1)},
      '{mk(OP_CANCEL, 15, 0, 0, 0, 100), 1, single(ST_NOT_ACTIVE, 0, 0, 0)},
      '{mk(OP_REFRESH, 3, 0, 0, 0, 100), 1, single(ST_NOT_ACTIVE, 0, 0, 0)},
      '{mk(OP_RESET, 4, 0, 0, 0, 100), 1, single(ST_OK, 0, 0, 0)},
      '{mk(OP_RESET, 4, 9, 0, 1, 100), 1, single(ST_NOT_ACTIVE, 0, 0, 0)},
      '{mk(OP_COLLECT, 0, 0, 0, 0, 100), 0, '0},
      '{mk(OP_ADD, 0, 50, 1, 0, 100), 1, single(ST_OK, 0, 1, 0)},
      '{mk(OP_ADD, 0, '1, 0, 0, '1), 1, single(ST_OK, 1, 0, 0)},
      '{mk(OP_ADD, 0, 10, 0, 1, 100), 0, '0},
      '{mk(OP_QUERY, 0, 0, 0, 0, 100), 0, '0},
      '{mk(OP_ADD, 0, 0, 1, 0, 100), 0, '0},
      '{mk(OP_RESET, 0, 20, 0, 0, 100), 0, '0},
      '{mk(OP_RESET, 1, 5, 0, 1, 120), 0, '0},
      '{mk(OP_REFRESH, 2, 0, 0, 0, 105), 0, '0},
      '{mk(OP_COLLECT, 0, 0, 0, 0, 130), 0, '0},
      '{mk(OP_COLLECT, 0, 0, 0, 0, 90), 0, '0},
      '{mk(OP_QUERY, 0, 0, 0, 0, 4000000), 0, '0},
      '{mk(OP_COLLECT, 0, 0, 0, 0, 4000000), 0, '0},
      '{mk(OP_COLLECT, 0, 0, 0, 0, 1), 0, '0},
      '{mk(3'd6, 0, 0, 0, 0, 1), 0, '0},
      '{mk(3'd7, 0, 0, 0, 0, 1), 0, '0}
    };

    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd);
      if (dir_rows[i].has_resp && last_pred != dir_rows[i].resp)
        report_mismatch("directed row", i, 0);
    end

    // fill the table, overflow it, and let the receiver stall long
    long_stall_req = 1;
    for (int i = 0; i < N_SLOTS + 1; i++)
      send_cmd(mk(OP_ADD, 0, $urandom_range(0, 40), 1'($urandom), 0, clock_ms));
    send_cmd(mk(OP_COLLECT, 0, 0, 0, 0, clock_ms + 100));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_threshold(32'd0);
        1: write_threshold('1);
        2: write_threshold(32'd150);
        default: write_threshold(DEFAULT_THRESHOLD);
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        rc = random_cmd();
        send_cmd(rc);
      end
    end
    in_valid <= 0;

    while (expected_resp_q.size() != 0) @(posedge clk);
    repeat (40 * N_SLOTS) @(posedge clk);
    if (errors == 0 && expected_resp_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
